// ===== design/bndc_pkg.sv =====
package bndc_pkg;

    // Payload and register field widths
    localparam int PIXEL_W      = 16;
    localparam int MASK_W       = 16;
    localparam int IMG_WIDTH_W  = 12;
    localparam int IMG_HEIGHT_W = 13;
    localparam int THRESH_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    // Default size limits for the top level parameters
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;

    // Smallest legal frame dimension
    localparam int MIN_DIM = 3;

    // Register values after reset
    localparam int                    RST_IMAGE_WIDTH  = 640;
    localparam int                    RST_IMAGE_HEIGHT = 480;
    localparam logic [THRESH_W-1:0]   RST_THRESHOLD    = THRESH_W'(5);

    // 3x3 neighborhood
    localparam int ROW_TAPS = 3;
    localparam int TAPS     = 9;
    localparam int SUM_W    = $clog2(TAPS + 1);

    // Result value for a set pixel
    localparam logic [MASK_W-1:0] MASK_SET = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = CFG_IDX_W'(2);

    // One row of the window: bits at offsets 0, -1, -2
    typedef logic [ROW_TAPS-1:0] t_row_bits;

endpackage

// ===== design/bndc_if.sv =====
// Pixel input channel
interface bndc_pixel_if import bndc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// Filtered result channel
interface bndc_mask_if import bndc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] mask_pixel;
    logic              previous_frame_tail;

    modport source (output valid, output mask_pixel, output previous_frame_tail, input ready);
    modport sink   (input valid, input mask_pixel, input previous_frame_tail, output ready);
endinterface

// Configuration write channel
interface bndc_cfg_if import bndc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/bndc_ram.sv =====
module bndc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    // one write port, two registered read ports; read data holds while disabled
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

// ===== design/binary_neighbor_count_despeckle.sv =====
// Path: a taken pixel beat passes the stage 1 and output registers.
// Throughput: one pixel per cycle without stalls; one write and two reads of the
// line memory per pixel, each read serving one earlier row of the window.
// Reset: synchronous, active low; clears the pipeline valids and the frame
// position and restores the register defaults. The line memory is not
// cleared and needs no clearing pass.
module binary_neighbor_count_despeckle
    import bndc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bndc_cfg_if.sink     i_cfg,
    bndc_pixel_if.sink   i_pix,
    bndc_mask_if.source  o_mask
);

    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int TOT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH = 2 * MAX_WIDTH + 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int PRD_W = W_W + H_W;

    localparam int RST_W   = (RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH;
    localparam int RST_H   = (RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT;
    localparam int RST_TOT = RST_W * RST_H;

    function automatic logic [1:0] row_count(input t_row_bits bits);
        row_count = 2'(bits[0]) + 2'(bits[1]) + 2'(bits[2]);
    endfunction

    // ---------------- configuration ----------------
    logic [W_W-1:0]      r_width;
    logic [H_W-1:0]      r_height;
    logic [TOT_W-1:0]    r_total;
    logic [THRESH_W-1:0] r_threshold;

    logic [IMG_WIDTH_W-1:0]  cfg_width_raw;
    logic [IMG_HEIGHT_W-1:0] cfg_height_raw;
    logic [W_W-1:0]          cfg_width_sat;
    logic [H_W-1:0]          cfg_height_sat;
    logic [W_W-1:0]          mul_w;
    logic [H_W-1:0]          mul_h;
    logic [PRD_W-1:0]        cfg_total_prod;

    assign i_cfg.ready    = 1'b1;
    assign cfg_width_raw  = i_cfg.data[IMG_WIDTH_W-1:0];
    assign cfg_height_raw = i_cfg.data[IMG_HEIGHT_W-1:0];

    // saturate sizes to the supported range
    always_comb begin
        if (cfg_width_raw < IMG_WIDTH_W'(MIN_DIM)) begin
            cfg_width_sat = W_W'(MIN_DIM);
        end else if (32'(cfg_width_raw) > 32'(MAX_WIDTH)) begin
            cfg_width_sat = W_W'(MAX_WIDTH);
        end else begin
            cfg_width_sat = W_W'(cfg_width_raw);
        end
        if (cfg_height_raw < IMG_HEIGHT_W'(MIN_DIM)) begin
            cfg_height_sat = H_W'(MIN_DIM);
        end else if (32'(cfg_height_raw) > 32'(MAX_HEIGHT)) begin
            cfg_height_sat = H_W'(MAX_HEIGHT);
        end else begin
            cfg_height_sat = H_W'(cfg_height_raw);
        end
    end

    // frame length follows each size write
    assign mul_w = (i_cfg.index == CFG_IMAGE_WIDTH) ? cfg_width_sat : r_width;
    assign mul_h = (i_cfg.index == CFG_IMAGE_HEIGHT) ? cfg_height_sat : r_height;
    assign cfg_total_prod = PRD_W'(mul_w) * PRD_W'(mul_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= W_W'(RST_W);
            r_height    <= H_W'(RST_H);
            r_total     <= TOT_W'(RST_TOT);
            r_threshold <= RST_THRESHOLD;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_IMAGE_WIDTH: begin
                    r_width <= cfg_width_sat;
                    r_total <= TOT_W'(cfg_total_prod);
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= cfg_height_sat;
                    r_total  <= TOT_W'(cfg_total_prod);
                end
                CFG_THRESHOLD: begin
                    r_threshold <= i_cfg.data[THRESH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic s1_advance;
    logic in_fire;

    assign out_free    = !r_out_valid || o_mask.ready;
    assign s1_advance  = r_s1_valid && out_free;
    assign i_pix.ready = !r_s1_valid || out_free;
    assign in_fire     = i_pix.valid && i_pix.ready;

    // ---------------- stage 0: position, borders, memory access ----------------
    logic [POS_W-1:0] r_pos;
    logic [AW-1:0]    r_wa;
    logic [1:0]       r_hist;

    logic             pix_nz;
    t_row_bits        row0_bits;
    logic [TOT_W-1:0] pos_ext;
    logic [TOT_W-1:0] pos_inc;
    logic [TOT_W-1:0] lim_tail;
    logic [TOT_W-1:0] lim_interior;
    logic             pos_wrap;
    logic             is_tail;
    logic             is_interior;
    logic [AW:0]      diff_row1;
    logic [AW:0]      diff_row2;
    logic [AW-1:0]    ra_row1;
    logic [AW-1:0]    ra_row2;

    assign pix_nz    = |i_pix.pixel_value;
    assign row0_bits = {r_hist[1], r_hist[0], pix_nz};

    assign pos_ext      = TOT_W'(r_pos);
    assign pos_inc      = pos_ext + TOT_W'(1);
    assign lim_tail     = TOT_W'(r_width) + TOT_W'(1);
    assign lim_interior = TOT_W'({r_width, 1'b0}) + TOT_W'(2);
    assign pos_wrap     = pos_inc >= r_total;
    assign is_tail      = pos_ext < lim_tail;
    assign is_interior  = (pos_ext >= lim_interior) && (pos_ext < r_total);

    // read one and two rows back, modulo the memory depth
    assign diff_row1 = {1'b0, r_wa} - (AW+1)'(r_width);
    assign diff_row2 = {1'b0, r_wa} - (AW+1)'({r_width, 1'b0});
    assign ra_row1   = diff_row1[AW] ? AW'(diff_row1 + (AW+1)'(DEPTH)) : diff_row1[AW-1:0];
    assign ra_row2   = diff_row2[AW] ? AW'(diff_row2 + (AW+1)'(DEPTH)) : diff_row2[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_wa  <= '0;
        end else if (in_fire) begin
            if (pos_wrap) begin
                r_pos <= '0;
                r_wa  <= '0;
            end else begin
                r_pos <= POS_W'(pos_inc);
                r_wa  <= (r_wa == AW'(DEPTH - 1)) ? '0 : r_wa + AW'(1);
            end
        end
    end

    // last two pixel bits, stored beside each new bit
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_hist <= {r_hist[0], pix_nz};
        end
    end

    t_row_bits rd_row1;
    t_row_bits rd_row2;

    bndc_ram #(
        .WIDTH (ROW_TAPS),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk       (i_clk),
        .i_wr_en     (in_fire),
        .i_wr_addr   (r_wa),
        .i_wr_data   (row0_bits),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (ra_row1),
        .i_rd_addr_b (ra_row2),
        .o_rd_data_a (rd_row1),
        .o_rd_data_b (rd_row2)
    );

    // ---------------- stage 1 ----------------
    t_row_bits r_s1_row0;
    logic      r_s1_interior;
    logic      r_s1_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_row0     <= row0_bits;
            r_s1_interior <= is_interior;
            r_s1_tail     <= is_tail;
        end
    end

    // count the nine taps and compare
    logic [SUM_W-1:0] tap_sum;
    logic             hit;

    assign tap_sum = SUM_W'(row_count(r_s1_row0)) + SUM_W'(row_count(rd_row1))
                   + SUM_W'(row_count(rd_row2));
    assign hit     = r_s1_interior && (THRESH_W'(tap_sum) >= r_threshold);

    // ---------------- output register ----------------
    logic [MASK_W-1:0] r_out_mask;
    logic              r_out_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_mask.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_mask <= hit ? MASK_SET : '0;
            r_out_tail <= r_s1_tail;
        end
    end

    assign o_mask.valid               = r_out_valid;
    assign o_mask.mask_pixel          = r_out_mask;
    assign o_mask.previous_frame_tail = r_out_tail;

    // ---------------- checks ----------------
    a_tail_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mask.valid && o_mask.previous_frame_tail |-> o_mask.mask_pixel == '0)
        else $error("tail beat carries a set mask");

    a_wa_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (AW+1)'(r_wa) < (AW+1)'(DEPTH))
        else $error("line memory write address out of range");

    a_frame_start_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == '0 |-> r_wa == '0)
        else $error("write address not aligned at frame start");

    a_beat_enters_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_s1_valid)
        else $error("accepted pixel beat lost before stage 1");

endmodule

// ===== tb/despeckle_checker.sv =====
// Watches the config, pixel and mask channels, predicts every mask beat
// and compares it with what the block sends.
module despeckle_checker
    import bndc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bndc_cfg_if          i_cfg,
    bndc_pixel_if        i_pix,
    bndc_mask_if         i_mask,
    output int           o_fail_count,
    output int           o_pending
);

    // History holds two rows plus three pixels at the widest setting
    localparam int HIST_DEPTH = 2 * MAX_WIDTH + 3;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [MASK_W-1:0] mask_pixel;
        logic              previous_frame_tail;
    } t_mask_beat;

    logic                    nz_hist [HIST_DEPTH];
    int unsigned             frame_pos;
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    logic [THRESH_W-1:0]     thresh_reg;
    t_mask_beat              expected_masks [$];
    int                      mismatches;

    function automatic int unsigned saturate(input int unsigned v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // Store the new pixel's bit, then judge the pixel one row and one
    // column back; the window wraps across row ends.
    function automatic t_mask_beat filter_next_pixel(input logic [PIXEL_W-1:0] value);
        int unsigned w, h, total, p, q, hits, dy, dx;
        t_mask_beat  res;
        w     = saturate(int'(width_reg), MAX_WIDTH);
        h     = saturate(int'(height_reg), MAX_HEIGHT);
        total = w * h;
        p     = frame_pos;
        res   = '0;
        nz_hist[p % HIST_DEPTH] = (value != '0);
        if (p < w + 1) begin
            res.previous_frame_tail = 1'b1;
        end else begin
            q = p - w - 1;
            // border pixels stay clear
            if (q >= w + 1 && q + w + 1 < total) begin
                hits = 0;
                for (dy = 0; dy < 3; dy++) begin
                    for (dx = 0; dx < 3; dx++) begin
                        if (nz_hist[(q - w - 1 + dy * w + dx) % HIST_DEPTH])
                            hits++;
                    end
                end
                if (hits >= thresh_reg)
                    res.mask_pixel = MASK_SET;
            end
        end
        // frame wrap, also when a smaller size was set mid-frame
        frame_pos = (p + 1 >= total) ? 0 : p + 1;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_mask_beat got;
        t_mask_beat want;
        if (!i_rst_n) begin
            foreach (nz_hist[i])
                nz_hist[i] = 1'b0;
            frame_pos  = 0;
            width_reg  = IMG_WIDTH_W'(RST_IMAGE_WIDTH);
            height_reg = IMG_HEIGHT_W'(RST_IMAGE_HEIGHT);
            thresh_reg = RST_THRESHOLD;
            expected_masks.delete();
            mismatches = 0;
        end else begin
            // mask beat against the oldest prediction
            if (i_mask.valid && i_mask.ready) begin
                got.mask_pixel          = i_mask.mask_pixel;
                got.previous_frame_tail = i_mask.previous_frame_tail;
                if (expected_masks.size() == 0) begin
                    if (mismatches < REPORT_MAX)
                        $display("%0t: mask beat with nothing pending: mask %h tail %b",
                                 $realtime, got.mask_pixel, got.previous_frame_tail);
                    mismatches++;
                end else begin
                    want = expected_masks.pop_front();
                    if (got.mask_pixel !== want.mask_pixel ||
                        got.previous_frame_tail !== want.previous_frame_tail) begin
                        if (mismatches < REPORT_MAX)
                            $display("%0t: mask exp %h got %h, tail exp %b got %b",
                                     $realtime, want.mask_pixel, got.mask_pixel,
                                     want.previous_frame_tail, got.previous_frame_tail);
                        mismatches++;
                    end
                end
            end
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_IMAGE_WIDTH:  width_reg  = i_cfg.data[IMG_WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT: height_reg = i_cfg.data[IMG_HEIGHT_W-1:0];
                    CFG_THRESHOLD:    thresh_reg = i_cfg.data[THRESH_W-1:0];
                    default: ;
                endcase
            end
            // pixel beat
            if (i_pix.valid && i_pix.ready)
                expected_masks.push_back(filter_next_pixel(i_pix.pixel_value));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_masks.size();
    end

endmodule

// ===== tb/tb_binary_neighbor_count_despeckle.sv =====
module tb_binary_neighbor_count_despeckle
    import bndc_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int EDGE_COUNT   = 12;
    // index 3 has no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);
    localparam logic [PIXEL_W-1:0] EDGE_PIXELS [EDGE_COUNT] = '{
        16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
        16'h0000, 16'h7FFF, 16'h0000, 16'hFFFE, 16'h0000, 16'h0100
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   beats_sent;
    int   cycles;
    int   send_idle;
    int   recv_idle;

    bndc_cfg_if   cfg_if ();
    bndc_pixel_if pix_if ();
    bndc_mask_if  mask_if ();

    binary_neighbor_count_despeckle dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_mask  (mask_if)
    );

    despeckle_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_if),
        .i_pix        (pix_if),
        .i_mask       (mask_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // mask sink stalls at random
    initial begin
        mask_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            mask_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic logic [PIXEL_W-1:0] rand_pixel(input int density);
        if ($urandom_range(99) < density)
            return PIXEL_W'($urandom_range(1, 65535));
        return '0;
    endfunction

    // One pixel beat; valid stays high afterwards unless the caller drops it
    task automatic send_pixel(input logic [PIXEL_W-1:0] value);
        if (beats_sent < 520) begin
            send_idle = 20;
            recv_idle <= 88;
        end else if (beats_sent < 1040) begin
            send_idle = 88;
            recv_idle <= 20;
        end else begin
            send_idle = 0;
            recv_idle <= 0;
        end
        while ($urandom_range(99) < send_idle) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= value;
        do @(posedge i_clk); while (!pix_if.ready);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Drain, reprogram all registers, then stream random pixels
    task automatic run_phase(input logic [CFG_DATA_W-1:0] width_val,
                             input logic [CFG_DATA_W-1:0] height_val,
                             input logic [CFG_DATA_W-1:0] thresh_val,
                             input int n_pixels, input int density, input bit spare);
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        if (spare)
            write_reg(CFG_SPARE, '1);
        write_reg(CFG_IMAGE_WIDTH, width_val);
        write_reg(CFG_IMAGE_HEIGHT, height_val);
        write_reg(CFG_THRESHOLD, thresh_val);
        cfg_if.valid <= 1'b0;
        repeat (n_pixels)
            send_pixel(rand_pixel(density));
    endtask

    initial begin
        int k;
        i_rst_n            <= 1'b0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= CFG_IMAGE_WIDTH;
        cfg_if.data        <= '0;
        pix_if.valid       <= 1'b0;
        pix_if.pixel_value <= '0;
        recv_idle          <= 88;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extreme pixel values at the reset sizes (all start-up padding)
        for (k = 0; k < EDGE_COUNT; k++)
            send_pixel(EDGE_PIXELS[k]);

        // shrink mid-frame to 3x3, threshold zero
        run_phase(13'd3, 13'd3, 13'd0, 40, 50, 1'b0);
        // sizes below the minimum saturate
        run_phase(13'd0, 13'd2, 13'd4, 60, 60, 1'b0);
        run_phase(13'd5, 13'd4, 13'd5, 100, 55, 1'b1);
        run_phase(13'd8, 13'd6, 13'd3, 150, 40, 1'b0);
        // all ones: width and height saturate high
        run_phase(13'h1FFF, 13'h1FFF, 13'd9, 60, 90, 1'b0);
        // threshold above nine
        run_phase(13'd7, 13'd5, 13'd10, 100, 80, 1'b0);
        run_phase(13'd16, 13'd8, 13'd255, 80, 70, 1'b0);
        run_phase(13'd6, 13'd6, 13'd1, 120, 15, 1'b0);
        run_phase(13'd2048, 13'd4096, 13'd2, 40, 50, 1'b0);
        run_phase(13'd4, 13'd3, 13'd6, 100, 60, 1'b0);
        run_phase(13'd10, 13'd10, 13'd7, 200, 75, 1'b0);

        // random small frames; unused upper data bits set at random
        for (k = 0; k < 5; k++)
            run_phase(CFG_DATA_W'($urandom_range(0, 12) | ($urandom_range(1) << 12)),
                      CFG_DATA_W'($urandom_range(3, 10)),
                      CFG_DATA_W'($urandom_range(0, 10) | ($urandom_range(31) << 8)),
                      100, $urandom_range(10, 90), 1'b0);

        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== binary_neighbor_count_despeckle.f =====
design/bndc_pkg.sv
design/bndc_if.sv
design/bndc_ram.sv
design/binary_neighbor_count_despeckle.sv
tb/despeckle_checker.sv
tb/tb_binary_neighbor_count_despeckle.sv
